@@ sv/smma_pkg.sv @@
`default_nettype none

package smma_pkg;

    localparam int ELEM_W     = 32;
    localparam int IDX_W      = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 3;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_OP_MODE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROWS_A    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_INNER_DIM = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_COLS_B    = 2'd3;

    // op_mode codes
    localparam logic [1:0] MODE_MUL  = 2'd0;
    localparam logic [1:0] MODE_ADD  = 2'd1;
    localparam logic [1:0] MODE_SUB  = 2'd2;
    localparam logic [1:0] MODE_RSVD = 2'd3;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_COMPUTE,
        ST_DRAIN
    } t_state;

    // one step of work for the datapath
    typedef struct packed {
        logic             valid;
        logic             first;   // first term of an element
        logic             klast;   // last term of an element
        logic             last;    // final element of the matrix
        logic             mul;
        logic             sub;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_cmd;

endpackage

`default_nettype wire

@@ sv/smma_ram.sv @@
`default_nettype none

module smma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/smma_ctrl.sv @@
`default_nettype none

module smma_ctrl #(
    parameter int MAX_DIM = 4
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic                                   i_cfg_we,
    input  wire logic [smma_pkg::CFG_ADDR_W-1:0]        i_cfg_index,
    input  wire logic [smma_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  wire logic                                   i_done,
    output logic                                        o_wr_en_a,
    output logic                                        o_wr_en_b,
    output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] o_wr_addr,
    output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] o_rd_addr_a,
    output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] o_rd_addr_b,
    output smma_pkg::t_cmd                              o_cmd
);

    import smma_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int SW    = $clog2(DEPTH + 1);

    function automatic logic [DW-1:0] eff_dim(input logic [2:0] v);
        logic [3:0] m;
        m = 4'(MAX_DIM);
        if (v == 3'd0) begin
            return DW'(1);
        end else if ({1'b0, v} > m) begin
            return DW'(MAX_DIM);
        end else begin
            return DW'(v);
        end
    endfunction

    logic [1:0]    r_op_mode;
    logic [2:0]    r_rows_a;
    logic [2:0]    r_inner_dim;
    logic [2:0]    r_cols_b;
    t_state        r_state, n_state;
    logic          r_in_b, n_in_b;
    logic [AW-1:0] r_wr_addr, n_wr_addr;
    logic [DW-1:0] r_row, n_row;
    logic [DW-1:0] r_col, n_col;
    logic [DW-1:0] r_k, n_k;
    logic [AW-1:0] r_a_ptr, n_a_ptr;
    logic [AW-1:0] r_b_ptr, n_b_ptr;
    logic [AW-1:0] r_b_base, n_b_base;

    logic [DW-1:0]   w_nr, w_nk, w_nc, w_res_cols;
    logic [2*DW-1:0] w_prod_a, w_prod_b;
    logic [SW-1:0]   w_size_a, w_size_b;
    logic            w_mul, w_sub, w_accept;
    logic            w_a_last, w_b_last;
    logic            w_klast, w_row_last, w_col_last, w_final;

    assign w_nr       = eff_dim(r_rows_a);
    assign w_nk       = eff_dim(r_inner_dim);
    assign w_nc       = eff_dim(r_cols_b);
    assign w_mul      = (r_op_mode == MODE_MUL) || (r_op_mode == MODE_RSVD);
    assign w_sub      = (r_op_mode == MODE_SUB);
    assign w_prod_a   = {{DW{1'b0}}, w_nr} * {{DW{1'b0}}, w_nk};
    assign w_prod_b   = {{DW{1'b0}}, w_nk} * {{DW{1'b0}}, w_nc};
    assign w_size_a   = SW'(w_prod_a);
    assign w_size_b   = w_mul ? SW'(w_prod_b) : w_size_a;
    assign w_res_cols = w_mul ? w_nc : w_nk;

    assign w_accept   = start && (r_state == ST_LOAD);
    assign w_a_last   = (SW'(r_wr_addr) == (w_size_a - SW'(1)));
    assign w_b_last   = (SW'(r_wr_addr) == (w_size_b - SW'(1)));
    assign w_klast    = !w_mul || (r_k == (w_nk - DW'(1)));
    assign w_row_last = (r_row == (w_nr - DW'(1)));
    assign w_col_last = (r_col == (w_res_cols - DW'(1)));
    assign w_final    = w_klast && w_row_last && w_col_last;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_accept && r_in_b && w_b_last && !i_cfg_we) begin
                    n_state = ST_COMPUTE;
                end
            end
            ST_COMPUTE: begin
                if (w_final) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_done) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        busy        = (r_state != ST_LOAD);
        o_wr_en_a   = w_accept && !r_in_b;
        o_wr_en_b   = w_accept && r_in_b;
        o_wr_addr   = r_wr_addr;
        o_rd_addr_a = r_a_ptr;
        o_rd_addr_b = r_b_ptr;
        o_cmd.valid = (r_state == ST_COMPUTE);
        o_cmd.first = (r_k == '0);
        o_cmd.klast = w_klast;
        o_cmd.last  = w_row_last && w_col_last;
        o_cmd.mul   = w_mul;
        o_cmd.sub   = w_sub;
        o_cmd.row   = IDX_W'(r_row);
        o_cmd.col   = IDX_W'(r_col);
    end

    // load and walk counters
    always_comb begin
        n_in_b    = r_in_b;
        n_wr_addr = r_wr_addr;
        n_row     = r_row;
        n_col     = r_col;
        n_k       = r_k;
        n_a_ptr   = r_a_ptr;
        n_b_ptr   = r_b_ptr;
        n_b_base  = r_b_base;

        if (i_cfg_we) begin
            n_in_b    = 1'b0;
            n_wr_addr = '0;
        end else if (w_accept) begin
            if (!r_in_b && w_a_last) begin
                n_in_b    = 1'b1;
                n_wr_addr = '0;
            end else if (r_in_b && w_b_last) begin
                n_in_b    = 1'b0;
                n_wr_addr = '0;
            end else begin
                n_wr_addr = r_wr_addr + AW'(1);
            end
        end

        if (r_state != ST_COMPUTE) begin
            n_row    = '0;
            n_col    = '0;
            n_k      = '0;
            n_a_ptr  = '0;
            n_b_ptr  = '0;
            n_b_base = '0;
        end else if (!w_klast) begin
            // next term: A steps one column, B one row
            n_k     = r_k + DW'(1);
            n_a_ptr = r_a_ptr + AW'(w_nr);
            n_b_ptr = r_b_ptr + AW'(1);
        end else begin
            n_k = '0;
            if (w_row_last) begin
                n_row = '0;
                n_col = r_col + DW'(1);
            end else begin
                n_row = r_row + DW'(1);
            end
            if (w_mul) begin
                n_a_ptr = AW'(n_row);
                if (w_row_last) begin
                    n_b_base = r_b_base + AW'(w_nk);
                    n_b_ptr  = r_b_base + AW'(w_nk);
                end else begin
                    n_b_ptr = r_b_base;
                end
            end else begin
                n_a_ptr = r_a_ptr + AW'(1);
                n_b_ptr = r_b_ptr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode   <= MODE_MUL;
            r_rows_a    <= 3'd4;
            r_inner_dim <= 3'd4;
            r_cols_b    <= 3'd4;
            r_state     <= ST_LOAD;
            r_in_b      <= 1'b0;
            r_wr_addr   <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_k         <= '0;
            r_a_ptr     <= '0;
            r_b_ptr     <= '0;
            r_b_base    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_OP_MODE:   r_op_mode   <= i_cfg_data[1:0];
                    REG_ROWS_A:    r_rows_a    <= i_cfg_data;
                    REG_INNER_DIM: r_inner_dim <= i_cfg_data;
                    REG_COLS_B:    r_cols_b    <= i_cfg_data;
                    default:       r_op_mode   <= r_op_mode;
                endcase
            end
            r_state   <= n_state;
            r_in_b    <= n_in_b;
            r_wr_addr <= n_wr_addr;
            r_row     <= n_row;
            r_col     <= n_col;
            r_k       <= n_k;
            r_a_ptr   <= n_a_ptr;
            r_b_ptr   <= n_b_ptr;
            r_b_base  <= n_b_base;
        end
    end

    a_done_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |-> (r_state == ST_DRAIN))
        else $error("result burst ended outside drain");

    a_cfg_restarts_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (r_state == ST_LOAD)) |=> (!r_in_b && (r_wr_addr == '0)))
        else $error("register write did not restart the load");

endmodule

`default_nettype wire

@@ sv/smma_dp.sv @@
`default_nettype none

module smma_dp #(
    parameter int MAX_DIM   = 4,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_wr_en_a,
    input  wire logic                                   i_wr_en_b,
    input  wire logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] i_wr_addr,
    input  wire logic [smma_pkg::ELEM_W-1:0]            i_wr_data,
    input  wire logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] i_rd_addr_a,
    input  wire logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] i_rd_addr_b,
    input  wire smma_pkg::t_cmd                         i_cmd,
    output logic                                        o_done,
    output logic                                        o_result_valid,
    output logic signed [smma_pkg::ELEM_W-1:0]          o_result_value,
    output logic [smma_pkg::IDX_W-1:0]                  o_result_row,
    output logic [smma_pkg::IDX_W-1:0]                  o_result_col,
    output logic                                        o_last_element
);

    import smma_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int PW    = 2 * ELEM_W;
    localparam int TW    = PW - FRAC_BITS;
    localparam int ACC_W = TW + 3;
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

    logic [ELEM_W-1:0]        w_qa, w_qb;
    logic signed [ELEM_W-1:0] w_a, w_b;
    logic signed [PW-1:0]     w_prod;
    logic signed [ELEM_W:0]   w_sum;
    logic [PW-1:0]            w_bias, w_rsum;
    logic signed [TW-1:0]     w_term;
    logic [ACC_W-ELEM_W:0]    w_hi;
    logic                     w_ovf;

    t_cmd                     r_c1, r_c2, r_c3, r_c4;
    logic signed [PW-1:0]     r_p;
    logic signed [TW-1:0]     r_term;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_valid;
    logic [ELEM_W-1:0]        r_out_value;
    logic [IDX_W-1:0]         r_out_row;
    logic [IDX_W-1:0]         r_out_col;
    logic                     r_out_last;

    smma_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_wr_en_a),
        .i_waddr (i_wr_addr),
        .i_wdata (i_wr_data),
        .i_raddr (i_rd_addr_a),
        .o_rdata (w_qa)
    );

    smma_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (i_wr_en_b),
        .i_waddr (i_wr_addr),
        .i_wdata (i_wr_data),
        .i_raddr (i_rd_addr_b),
        .o_rdata (w_qb)
    );

    assign w_a    = w_qa;
    assign w_b    = w_qb;
    assign w_prod = PW'(w_a) * PW'(w_b);
    assign w_sum  = r_c1.sub ? ((ELEM_W+1)'(w_a) - (ELEM_W+1)'(w_b))
                             : ((ELEM_W+1)'(w_a) + (ELEM_W+1)'(w_b));

    // round half away from zero: a negative product takes half minus one
    assign w_bias = r_p[PW-1] ? (HALF - PW'(1)) : HALF;
    assign w_rsum = r_p + w_bias;
    assign w_term = r_c2.mul ? w_rsum[PW-1:FRAC_BITS] : TW'(r_p);

    assign w_hi  = r_acc[ACC_W-1:ELEM_W-1];
    assign w_ovf = !((&w_hi) || (~|w_hi));

    always_ff @(posedge i_clk) begin
        r_p    <= r_c1.mul ? w_prod : PW'(w_sum);
        r_term <= w_term;
        if (r_c3.first) begin
            r_acc <= ACC_W'(r_term);
        end else begin
            r_acc <= r_acc + ACC_W'(r_term);
        end
        if (w_ovf) begin
            r_out_value <= r_acc[ACC_W-1] ? {1'b1, {(ELEM_W-1){1'b0}}}
                                          : {1'b0, {(ELEM_W-1){1'b1}}};
        end else begin
            r_out_value <= r_acc[ELEM_W-1:0];
        end
        r_out_row  <= r_c4.row;
        r_out_col  <= r_c4.col;
        r_out_last <= r_c4.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1        <= '0;
            r_c2        <= '0;
            r_c3        <= '0;
            r_c4        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_c1        <= i_cmd;
            r_c2        <= r_c1;
            r_c3        <= r_c2;
            r_c4        <= r_c3;
            r_out_valid <= r_c4.valid && r_c4.klast;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_result_row   = r_out_row;
    assign o_result_col   = r_out_col;
    assign o_last_element = r_out_last;
    assign o_done         = r_out_valid && r_out_last;

    a_quiet_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |=> !r_out_valid)
        else $error("result beat after the final element");

    a_element_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c4.valid && r_c4.klast) |=> r_out_valid)
        else $error("finished element produced no result beat");

endmodule

`default_nettype wire

@@ sv/small_matrix_multiply_add_sub_top.sv @@
`default_nettype none

// Small matrix engine, signed fixed point with FRAC_BITS fraction bits.
// Load A and then B one element per beat, column-major, by pulsing start
// while busy is low. Register writes restart the load. When the last
// B element is taken busy rises and the result matrix comes out
// column-major, one beat per element on o_result_valid, which the
// receiver cannot hold off. A single shared multiplier and accumulator
// walk the result: a multiply result element sums inner_dim terms, an
// add or subtract element is a single term. Results pass through the
// RAM read, multiply, round, accumulate and saturate registers in that
// order; busy falls the cycle after the final beat.
module small_matrix_multiply_add_sub_top #(
    parameter int MAX_DIM   = 4,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic signed [smma_pkg::ELEM_W-1:0] i_element_value,
    input  wire logic                               i_cfg_we,
    input  wire logic [smma_pkg::CFG_ADDR_W-1:0]    i_cfg_index,
    input  wire logic [smma_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                    o_result_valid,
    output logic signed [smma_pkg::ELEM_W-1:0]      o_result_value,
    output logic [smma_pkg::IDX_W-1:0]              o_result_row,
    output logic [smma_pkg::IDX_W-1:0]              o_result_col,
    output logic                                    o_last_element
);

    import smma_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          w_done;
    logic          w_wr_en_a, w_wr_en_b;
    logic [AW-1:0] w_wr_addr, w_rd_addr_a, w_rd_addr_b;
    t_cmd          w_cmd;

    smma_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_done      (w_done),
        .o_wr_en_a   (w_wr_en_a),
        .o_wr_en_b   (w_wr_en_b),
        .o_wr_addr   (w_wr_addr),
        .o_rd_addr_a (w_rd_addr_a),
        .o_rd_addr_b (w_rd_addr_b),
        .o_cmd       (w_cmd)
    );

    smma_dp #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr_en_a      (w_wr_en_a),
        .i_wr_en_b      (w_wr_en_b),
        .i_wr_addr      (w_wr_addr),
        .i_wr_data      (i_element_value),
        .i_rd_addr_a    (w_rd_addr_a),
        .i_rd_addr_b    (w_rd_addr_b),
        .i_cmd          (w_cmd),
        .o_done         (w_done),
        .o_result_valid (o_result_valid),
        .o_result_value (o_result_value),
        .o_result_row   (o_result_row),
        .o_result_col   (o_result_col),
        .o_last_element (o_last_element)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import smma_pkg::*;

    localparam int MAX_DIM      = 4;
    localparam int FRAC_BITS    = 16;
    localparam int TOTAL_ELEMS  = 425;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [ELEM_W-1:0] value;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              last;
    } t_matrix_elem;

    typedef enum logic {
        ROW_CFG,
        ROW_ELEM
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [ELEM_W-1:0]     elem;
        logic                  typed;
        logic [ELEM_W-1:0]     typed_val;
    } t_plan_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic signed [ELEM_W-1:0]     i_element_value = '0;
    logic                         i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]        i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data = '0;
    logic                         busy;
    logic                         o_result_valid;
    logic signed [ELEM_W-1:0]     o_result_value;
    logic [IDX_W-1:0]             o_result_row;
    logic [IDX_W-1:0]             o_result_col;
    logic                         o_last_element;

    // mirror of the block's registers and stores
    logic [1:0]               mode_reg = MODE_MUL;
    logic [2:0]               rows_reg = 3'd4;
    logic [2:0]               inner_reg = 3'd4;
    logic [2:0]               cols_reg = 3'd4;
    int                       fill_count = 0;
    logic signed [ELEM_W-1:0] a_mem [MAX_DIM*MAX_DIM];
    logic signed [ELEM_W-1:0] b_mem [MAX_DIM*MAX_DIM];

    t_matrix_elem      expected_elems [$];
    bit                hand_checked = 1'b0;
    logic [ELEM_W-1:0] hand_value = '0;
    int                err_count = 0;
    int                sent = 0;

    // directed part: extremes, rounding ties, every mode, reload on write
    t_plan_row plan [35] = '{
        '{ROW_CFG,  REG_OP_MODE,   3'(MODE_MUL),  32'h0,         1'b0, 32'h0},
        '{ROW_CFG,  REG_ROWS_A,    3'd1,          32'h0,         1'b0, 32'h0},
        '{ROW_CFG,  REG_INNER_DIM, 3'd1,          32'h0,         1'b0, 32'h0},
        '{ROW_CFG,  REG_COLS_B,    3'd1,          32'h0,         1'b0, 32'h0},
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'h7fff_ffff, 1'b0, 32'h0},
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'h7fff_ffff, 1'b1, 32'h7fff_ffff},
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'h8000_0000, 1'b0, 32'h0},
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'h8000_0000, 1'b1, 32'h7fff_ffff},
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'h8000_0000, 1'b0, 32'h0},
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'h7fff_ffff, 1'b1, 32'h8000_0000},
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'h0000_0001, 1'b0, 32'h0},
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'h0000_8000, 1'b1, 32'h0000_0001},
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'hffff_ffff, 1'b0, 32'h0},
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'h0000_8000, 1'b1, 32'hffff_ffff},
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'h0001_8000, 1'b0, 32'h0},
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'h0002_0000, 1'b1, 32'h0003_0000},
        '{ROW_CFG,  REG_OP_MODE,   3'(MODE_ADD),  32'h0,         1'b0, 32'h0},
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'h7fff_ffff, 1'b0, 32'h0},
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'h0000_0001, 1'b1, 32'h7fff_ffff},
        '{ROW_CFG,  REG_OP_MODE,   3'(MODE_SUB),  32'h0,         1'b0, 32'h0},
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'h8000_0000, 1'b0, 32'h0},
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'h0000_0001, 1'b1, 32'h8000_0000},
        // a load that holds only A gets dropped by the register write
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'h0005_0000, 1'b0, 32'h0},
        '{ROW_CFG,  REG_COLS_B,    3'd1,          32'h0,         1'b0, 32'h0},
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'hfffe_0000, 1'b0, 32'h0},
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'h0001_0000, 1'b1, 32'hfffd_0000},
        // reserved mode multiplies; zero dims act as 1, 7 acts as MAX_DIM
        '{ROW_CFG,  REG_OP_MODE,   3'(MODE_RSVD), 32'h0,         1'b0, 32'h0},
        '{ROW_CFG,  REG_ROWS_A,    3'd0,          32'h0,         1'b0, 32'h0},
        '{ROW_CFG,  REG_INNER_DIM, 3'd0,          32'h0,         1'b0, 32'h0},
        '{ROW_CFG,  REG_COLS_B,    3'd7,          32'h0,         1'b0, 32'h0},
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'h0002_0000, 1'b0, 32'h0},
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'h0001_0000, 1'b0, 32'h0},
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'hffff_8000, 1'b0, 32'h0},
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'h7fff_ffff, 1'b0, 32'h0},
        '{ROW_ELEM, REG_OP_MODE,   3'd0,          32'h8000_0000, 1'b0, 32'h0}
    };

    small_matrix_multiply_add_sub_top #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_element_value (i_element_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_result_valid  (o_result_valid),
        .o_result_value  (o_result_value),
        .o_result_row    (o_result_row),
        .o_result_col    (o_result_col),
        .o_last_element  (o_last_element)
    );

    always #5 i_clk = ~i_clk;

    function automatic int clamp_dim(logic [2:0] v);
        if (v == 3'd0) return 1;
        if (int'(v) > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic bit is_mul();
        return (mode_reg == MODE_MUL) || (mode_reg == MODE_RSVD);
    endfunction

    function automatic int load_length();
        int na;
        na = clamp_dim(rows_reg) * clamp_dim(inner_reg);
        return na + (is_mul() ? clamp_dim(inner_reg) * clamp_dim(cols_reg) : na);
    endfunction

    // round to nearest, ties away from zero
    function automatic longint round_q(longint p);
        longint mag;
        mag = (p < 0) ? -p : p;
        mag = (mag + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return (p < 0) ? -mag : mag;
    endfunction

    function automatic logic [ELEM_W-1:0] sat32(longint v);
        if (v > longint'(32'sh7fff_ffff)) return 32'h7fff_ffff;
        if (v < -longint'(64'h8000_0000)) return 32'h8000_0000;
        return v[ELEM_W-1:0];
    endfunction

    function automatic void apply_reg_write(logic [CFG_ADDR_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_OP_MODE:   mode_reg = d[1:0];
            REG_ROWS_A:    rows_reg = d;
            REG_INNER_DIM: inner_reg = d;
            REG_COLS_B:    cols_reg = d;
            default: ;
        endcase
        fill_count = 0;
    endfunction

    // store one element; on the last B element queue the whole result matrix, or only the hand-checked value
    function automatic void absorb_element(logic signed [ELEM_W-1:0] v);
        int nr, nk, nc, size_a, res_cols;
        longint acc;
        t_matrix_elem e;
        nr = clamp_dim(rows_reg);
        nk = clamp_dim(inner_reg);
        nc = clamp_dim(cols_reg);
        size_a = nr * nk;
        res_cols = is_mul() ? nc : nk;
        if (fill_count < size_a) a_mem[fill_count] = v;
        else b_mem[fill_count - size_a] = v;
        fill_count++;
        if (fill_count < load_length()) return;
        fill_count = 0;
        if (hand_checked) begin
            e = '{value: hand_value, row: '0, col: '0, last: 1'b1};
            expected_elems.push_back(e);
            return;
        end
        for (int c = 0; c < res_cols; c++) begin
            for (int r = 0; r < nr; r++) begin
                acc = 0;
                if (is_mul()) begin
                    for (int k = 0; k < nk; k++)
                        acc += round_q(longint'(a_mem[r + nr*k]) * longint'(b_mem[k + nk*c]));
                end else if (mode_reg == MODE_ADD) begin
                    acc = longint'(a_mem[r + nr*c]) + longint'(b_mem[r + nr*c]);
                end else begin
                    acc = longint'(a_mem[r + nr*c]) - longint'(b_mem[r + nr*c]);
                end
                e.value = sat32(acc);
                e.row = r[IDX_W-1:0];
                e.col = c[IDX_W-1:0];
                e.last = (c == res_cols - 1) && (r == nr - 1);
                expected_elems.push_back(e);
            end
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_matrix_elem want;
        if (i_rst_n) begin
            if (o_result_valid) begin
                if (expected_elems.size() == 0) begin
                    $display("%0t: unexpected beat value=%h row=%0d col=%0d last=%0b",
                             $time, o_result_value, o_result_row, o_result_col,
                             o_last_element);
                    err_count++;
                end else begin
                    want = expected_elems.pop_front();
                    if (o_result_value !== want.value) begin
                        $display("%0t: value expected %h got %h", $time, want.value,
                                 o_result_value);
                        err_count++;
                    end
                    if (o_result_row !== want.row) begin
                        $display("%0t: row expected %0d got %0d", $time, want.row,
                                 o_result_row);
                        err_count++;
                    end
                    if (o_result_col !== want.col) begin
                        $display("%0t: col expected %0d got %0d", $time, want.col,
                                 o_result_col);
                        err_count++;
                    end
                    if (o_last_element !== want.last) begin
                        $display("%0t: last expected %0b got %0b", $time, want.last,
                                 o_last_element);
                        err_count++;
                    end
                end
            end
            if (i_cfg_we) apply_reg_write(i_cfg_index, i_cfg_data);
            if (start && !busy) absorb_element(i_element_value);
        end
    end

    // drop start and let the block drain before touching registers
    task automatic wait_quiet();
        start = 1'b0;
        while (expected_elems.size() != 0 || busy) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        wait_quiet();
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = d;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_element(logic [ELEM_W-1:0] v, int gap);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_element_value = v;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        hand_checked = 1'b0;
        sent++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        int unsigned r;
        r = $urandom_range(0, 11);
        if (r >= 8) return 3'd4;
        return r[2:0];
    endfunction

    function automatic logic [ELEM_W-1:0] pick_elem();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4) return $urandom;
        if (r < 8) return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
        case ($urandom_range(0, 3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    initial begin : stimulus
        int total, cut, i;
        bit broken, steady;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[n]) begin
            if (plan[n].kind == ROW_CFG) begin
                write_reg(plan[n].reg_idx, plan[n].reg_val);
            end else begin
                hand_checked = plan[n].typed;
                hand_value = plan[n].typed_val;
                send_element(plan[n].elem, $urandom_range(0, 7));
            end
        end

        while (sent < TOTAL_ELEMS) begin
            write_reg(REG_OP_MODE, 3'($urandom_range(0, 3)));
            write_reg(REG_ROWS_A, pick_dim());
            write_reg(REG_INNER_DIM, pick_dim());
            write_reg(REG_COLS_B, pick_dim());
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3)) begin
                total = load_length();
                broken = ($urandom_range(0, 9) == 0);
                cut = $urandom_range(1, total - 1);
                i = 0;
                while (i < total) begin
                    // abandon the partial load with a register write
                    if (broken && i == cut) begin
                        write_reg(REG_OP_MODE, {1'b0, mode_reg});
                        broken = 1'b0;
                        i = 0;
                    end
                    send_element(pick_elem(), steady ? 0 : $urandom_range(0, 7));
                    i++;
                end
            end
        end

        wait_quiet();
        if (err_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
